@@ design/blzd_pkg.sv @@
// Shared types, constants and the character table of the byte LZ code decoder.
package blzd_pkg;

   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   localparam int CNT_W = 17;
   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   localparam int DIST_W = 12;
   localparam int LEN_W  = 5;

   localparam logic [7:0] REF_BASE   = 8'h3c;
   localparam int         TABLE_SIZE = 59;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // Command from the front end to the back end: one literal byte or one history copy.
   typedef struct packed {
      logic              restart;
      logic              is_copy;
      logic [7:0]        data;
      logic [DIST_W-1:0] copy_dist;
      logic [LEN_W-1:0]  len;
   } cmd_type;

   localparam logic [7:0] CHAR_TABLE [TABLE_SIZE] = '{
      8'h0a, 8'h20,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a,
      8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
      8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
      8'h21, 8'h23, 8'h25, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5b, 8'h5d, 8'h3c,
      8'h3e, 8'h2b, 8'h3d, 8'h2f, 8'h2a, 8'h3a, 8'h3b, 8'h2e, 8'h2c, 8'h7e,
      8'h5f
   };

endpackage

@@ design/blzd_front.sv @@
// Front end: accepts requests, pairs token bytes and issues literal or copy commands.
module blzd_front import blzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   output cmd_type     cmd_data,
   output logic        cmd_push,
   input  logic        queue_full
);

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ESC  = 2'd1;
   localparam logic [1:0] PEND_REF  = 2'd2;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       pend_ff, pend_in;
   logic [7:0]       held_ff, held_in;
   logic             stop_ff, stop_in;
   logic             restart_ff, restart_in;
   logic [15:0]      exp_len_ff;

   logic             accept;
   logic [CNT_W-1:0] cur_count;
   logic [1:0]       cur_pend;
   logic             cur_stop;
   logic [7:0]       ref_hi;
   logic [DIST_W-1:0] ref_dist;
   logic [LEN_W-1:0] len;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
      logic [CNT_W:0] sum;
      sum = {1'b0, a} + {{(CNT_W+1-LEN_W){1'b0}}, b};
      return sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
   endfunction

   assign accept     = req_tvalid && !queue_full;
   assign req_tready = !queue_full;
   assign ref_hi     = held_ff - REF_BASE;
   assign ref_dist   = {ref_hi, req_tdata[3:0]};
   assign len        = {1'b0, req_tdata[7:4]} + LEN_W'(2);

   always_comb begin
      count_in   = count_ff;
      pend_in    = pend_ff;
      held_in    = held_ff;
      stop_in    = stop_ff;
      restart_in = restart_ff;
      cmd_push   = 1'b0;
      cmd_data   = '{restart: 1'b0, is_copy: 1'b0, data: req_tdata,
                     copy_dist: ref_dist, len: LEN_W'(1)};
      cur_count  = req_tuser ? '0 : count_ff;
      cur_pend   = req_tuser ? PEND_NONE : pend_ff;
      cur_stop   = req_tuser ? 1'b0 : stop_ff;
      if (accept) begin
         count_in   = cur_count;
         pend_in    = cur_pend;
         stop_in    = cur_stop;
         held_in    = req_tuser ? 8'h00 : held_ff;
         restart_in = restart_ff || req_tuser;
         if (!cur_stop) begin
            pend_in = PEND_NONE;
            unique case (cur_pend)
               PEND_ESC: begin
                  if (req_tdata == 8'h00) begin
                     stop_in = 1'b1;
                  end else begin
                     cmd_push = 1'b1;
                     count_in = sat_add(cur_count, LEN_W'(1));
                  end
               end
               PEND_REF: begin
                  if (cur_count >= {{(CNT_W-DIST_W){1'b0}}, ref_dist}) begin
                     if (ref_dist == '0) begin
                        stop_in = 1'b1;
                     end else begin
                        cmd_push         = 1'b1;
                        cmd_data.is_copy = 1'b1;
                        cmd_data.len     = len;
                        count_in         = sat_add(cur_count, len);
                     end
                  end
               end
               default: begin
                  priority if (cur_count >= {{(CNT_W-16){1'b0}}, exp_len_ff}) begin
                     // length reached: drop the byte
                  end else if (req_tdata >= REF_BASE) begin
                     held_in = req_tdata;
                     pend_in = PEND_REF;
                  end else if (req_tdata == 8'h00) begin
                     pend_in = PEND_ESC;
                  end else begin
                     cmd_push      = 1'b1;
                     cmd_data.data = CHAR_TABLE[6'(req_tdata - 8'd1)];
                     count_in      = sat_add(cur_count, LEN_W'(1));
                  end
               end
            endcase
         end
         cmd_data.restart = restart_in;
         if (cmd_push) begin
            restart_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pend_ff    <= PEND_NONE;
         held_ff    <= 8'h00;
         stop_ff    <= 1'b0;
         restart_ff <= 1'b0;
         exp_len_ff <= 16'h0000;
      end else begin
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         held_ff    <= held_in;
         stop_ff    <= stop_in;
         restart_ff <= restart_in;
         if (csr_we) begin
            exp_len_ff <= csr_wdata;
         end
      end
   end

endmodule

@@ design/blzd_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module blzd_cmd_fifo import blzd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type        entry_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QAW:0]   fill_ff;
   logic           do_push, do_pop;

   assign full    = (fill_ff == (QAW+1)'(QDEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QAW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QAW'(1);
         end
         unique case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + (QAW+1)'(1);
            2'b01:   fill_ff <= fill_ff - (QAW+1)'(1);
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

@@ design/blzd_back.sv @@
// Back end: runs commands byte by byte against the history memory and drives the output.
module blzd_back import blzd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    q_head,
   input  logic       q_empty,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   localparam logic [HIST_AW:0]   DEPTH_X = (HIST_AW+1)'(HIST_DEPTH);
   localparam logic [HIST_AW-1:0] LAST_A  = HIST_AW'(HIST_DEPTH - 1);

   logic [7:0] hist_mem [HIST_DEPTH];

   // issue stage
   logic              a_busy_ff, a_busy_in;
   logic              a_copy_ff;
   logic [7:0]        a_data_ff;
   logic [DIST_W-1:0] a_dist_ff;
   logic [LEN_W-1:0]  a_rem_ff, a_rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [HIST_AW-1:0] wptr_ff, wptr_in;

   // output stage
   logic               b_valid_ff, b_valid_in;
   logic               b_copy_ff, b_byp_ff, b_last_ff;
   logic [7:0]         b_data_ff, rdata_ff;
   logic [HIST_AW-1:0] b_waddr_ff;

   logic               load, a_fire, b_fire, byp_hit;
   logic [HIST_AW:0]   wptr_x, dist_x, rd_x;
   logic [HIST_AW-1:0] rd_addr;
   logic [7:0]         out_data;

   assign load   = !a_busy_ff && !q_empty;
   assign q_pop  = load;
   assign b_fire = b_valid_ff && rsp_tready;
   assign a_fire = a_busy_ff && (!b_valid_ff || rsp_tready);

   assign wptr_x  = {1'b0, wptr_ff};
   assign dist_x  = {{(HIST_AW+1-DIST_W){1'b0}}, a_dist_ff};
   assign rd_x    = (wptr_x >= dist_x) ? (wptr_x - dist_x) : (wptr_x + DEPTH_X - dist_x);
   assign rd_addr = rd_x[HIST_AW-1:0];
   // the byte leaving the output stage is written this cycle: forward it
   assign byp_hit = a_copy_ff && b_valid_ff && (rd_addr == b_waddr_ff);

   assign out_data   = (b_copy_ff && !b_byp_ff) ? rdata_ff : b_data_ff;
   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = out_data;
   assign rsp_tlast  = b_last_ff;

   always_comb begin
      a_busy_in  = a_busy_ff;
      a_rem_in   = a_rem_ff;
      cnt_in     = cnt_ff;
      wptr_in    = wptr_ff;
      b_valid_in = b_valid_ff;
      if (load) begin
         a_busy_in = 1'b1;
         a_rem_in  = q_head.len;
         if (q_head.restart) begin
            cnt_in  = '0;
            wptr_in = '0;
         end
      end else if (a_fire) begin
         a_rem_in = a_rem_ff - LEN_W'(1);
         if (a_rem_ff == LEN_W'(1)) begin
            a_busy_in = 1'b0;
         end
         if (cnt_ff != COUNT_MAX) begin
            cnt_in  = cnt_ff + CNT_W'(1);
            wptr_in = (wptr_ff == LAST_A) ? '0 : wptr_ff + HIST_AW'(1);
         end
      end
      if (a_fire) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_busy_ff  <= 1'b0;
         a_rem_ff   <= '0;
         cnt_ff     <= '0;
         wptr_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         a_busy_ff  <= a_busy_in;
         a_rem_ff   <= a_rem_in;
         cnt_ff     <= cnt_in;
         wptr_ff    <= wptr_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_copy_ff <= q_head.is_copy;
         a_data_ff <= q_head.data;
         a_dist_ff <= q_head.copy_dist;
      end
      if (a_fire) begin
         b_copy_ff  <= a_copy_ff;
         b_byp_ff   <= byp_hit;
         b_last_ff  <= (a_rem_ff == LEN_W'(1));
         b_waddr_ff <= wptr_ff;
         b_data_ff  <= byp_hit ? out_data : a_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         hist_mem[b_waddr_ff] <= out_data;
      end
      if (a_fire && a_copy_ff) begin
         rdata_ff <= hist_mem[rd_addr];
      end
   end

endmodule

@@ design/byte_lz_code_decoder_top.sv @@
// Top level of the byte LZ code decoder: front end, command queue and back end.
//
//   channel   direction  handshake              payload
//   req_*     in         req_tvalid/req_tready  tdata = in_byte, tuser = stream_start
//   rsp_*     out        rsp_tvalid/rsp_tready  tdata = out_byte, tlast = run_last
//   csr_*     in         csr_we                 csr_wdata = expected_length
//
// A request is taken whenever the four-entry command queue has room.
// The back end emits one byte per cycle while it expands a command and rsp_tready is high,
// using its single history memory port pair; it loads the next command from the queue only
// once it is through with the last one.
// reset is synchronous and active high; it clears all control state. The history memory
// is not cleared and needs no clearing pass: reads only reach bytes of the current stream.
// A stalled rsp_tready holds the output byte; requests keep flowing until the queue fills.
module byte_lz_code_decoder_top import blzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,    // expected_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tuser,    // [0] stream_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast     // run_last
);

   cmd_type cmd_data, q_head;
   logic    cmd_push, q_pop, q_empty, q_full;

   // classify bytes and track count, pending token and stop state
   blzd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_data   (cmd_data),
      .cmd_push   (cmd_push),
      .queue_full (q_full)
   );

   // decouple request intake from byte emission
   blzd_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // expand commands into bytes and update history
   blzd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/blzd_checker.sv @@
// Port-level checks of the byte LZ code decoder, bound to its top level.
module blzd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // decoding stops before a zero byte, so none is ever shown
   a_no_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata != 8'h00))
      else $error("zero byte on response channel");

   // a stalled response holds its byte and its last flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled response changed");

   // reset empties the output stage
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // reset empties the command queue, so a request can be taken at once
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request channel not ready after reset");

endmodule

bind byte_lz_code_decoder_top blzd_checker u_chk (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for byte_lz_code_decoder_top: directed and random token streams.
module testbench;

   // Sizes and codes of the decoded format.
   localparam int          HISTORY_DEPTH  = blzd_pkg::HIST_DEPTH;
   localparam logic [7:0]  ESCAPE_CODE    = 8'h00;
   localparam logic [7:0]  LAST_CHAR_CODE = 8'h3b;
   localparam logic [7:0]  COPY_BASE      = 8'h3c;
   localparam logic [16:0] PRODUCED_TOP   = '1;

   // Character table, first entry in the top byte.
   localparam logic [59*8-1:0] CHAR_SET =
      "\n 0123456789abcdefghijklmnopqrstuvwxyz!#%(){}[]<>+=/*:;.,~_";

   // Run control.
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 100;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum logic [1:0] {TOKEN_NONE, TOKEN_ESCAPE, TOKEN_COPY} token_type;

   typedef struct packed {
      logic [7:0] code;
      logic       start;
   } request_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_type;

   // Block ports; every input starts at a known value.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [15:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   // Decoder state as predicted here.
   logic [7:0]  history_mem [HISTORY_DEPTH];
   logic [16:0] produced      = '0;
   token_type   token_pending = TOKEN_NONE;
   logic [7:0]  held_code     = '0;
   logic        halted        = 1'b0;
   logic [15:0] length_limit  = '0;

   // Traffic bookkeeping.
   request_type pending_reqs [$];
   request_type offered;
   decoded_type decoded_bytes [$];
   logic [7:0]  step_bytes [$];
   logic        new_stream   = 1'b0;
   int          pushed_count = 0;
   int          tx_idle_pct  = 0;
   int          rx_idle_pct  = 0;
   logic        rsp_hold     = 1'b0;
   int          errors       = 0;
   int          cycle_count  = 0;

   byte_lz_code_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] in_byte
      .req_tuser  (req_tuser),    // [0] stream_start
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Record one decoded byte in the history; a zero halts the stream instead.
   function automatic bit put_decoded(logic [7:0] c);
      if (c == 8'h00) begin
         halted = 1'b1;
         return 1'b0;
      end
      history_mem[produced % HISTORY_DEPTH] = c;
      if (produced != PRODUCED_TOP)
         produced++;
      step_bytes.insert(step_bytes.size(), c);
      return 1'b1;
   endfunction

   // Decode one accepted request and queue the bytes it yields, last one flagged.
   task automatic decode_request(request_type r);
      int unsigned copy_dist;
      int unsigned len;
      logic [7:0]  c;
      decoded_type d;
      step_bytes.delete();
      if (r.start) begin
         produced      = '0;
         token_pending = TOKEN_NONE;
         held_code     = '0;
         halted        = 1'b0;
      end
      if (!halted) begin
         case (token_pending)
            TOKEN_ESCAPE: begin
               token_pending = TOKEN_NONE;
               void'(put_decoded(r.code));
            end
            TOKEN_COPY: begin
               copy_dist = (int'(held_code) - int'(COPY_BASE)) * 16 + int'(r.code[3:0]);
               len  = int'(r.code[7:4]) + 2;
               token_pending = TOKEN_NONE;
               // Drop the whole copy when the history is too short.
               if (produced >= copy_dist) begin
                  for (int i = 0; i < len; i++) begin
                     c = (copy_dist == 0) ? 8'h00
                                          : history_mem[(produced - copy_dist) % HISTORY_DEPTH];
                     if (!put_decoded(c))
                        break;
                  end
               end
            end
            default: begin
               token_pending = TOKEN_NONE;
               // Start no new token once the length is reached.
               if (!(produced >= length_limit)) begin
                  if (r.code >= COPY_BASE) begin
                     held_code     = r.code;
                     token_pending = TOKEN_COPY;
                  end else if (r.code == ESCAPE_CODE) begin
                     token_pending = TOKEN_ESCAPE;
                  end else begin
                     void'(put_decoded(
                        CHAR_SET[(int'(LAST_CHAR_CODE) - int'(r.code)) * 8 +: 8]));
                  end
               end
            end
         endcase
      end
      foreach (step_bytes[i]) begin
         d.data = step_bytes[i];
         d.last = (i == step_bytes.size() - 1);
         decoded_bytes.insert(decoded_bytes.size(), d);
      end
   endtask

   // Sender: predict on acceptance, then present the next pending request or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            decode_request(offered);
         // Hold the current request while it is stalled.
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               offered = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered.code;
               req_tuser  <= offered.start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted byte against the oldest prediction, then stall at random.
   always @(posedge clock) begin : rx_side
      decoded_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_bytes.size() == 0) begin
               $error("out_byte: expected none, actual %h", rsp_tdata);
               errors++;
            end else begin
               want = decoded_bytes.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %h, actual %h", want.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("run_last: expected %b, actual %b", want.last, rsp_tlast);
                  errors++;
               end
            end
         end
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("byte_lz_code_decoder_top verification failed");
         $finish;
      end
   end

   // Queue one request; the first one after new_stream is set opens a stream.
   task automatic push_req(logic [7:0] code);
      request_type r;
      r.code  = code;
      r.start = new_stream;
      pending_reqs.insert(pending_reqs.size(), r);
      new_stream = 1'b0;
      pushed_count++;
   endtask

   // Write expected_length while the block is idle and mirror it in the predictor.
   task automatic write_length(logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      length_limit = value;
      @(negedge clock);
   endtask

   // Wait until every request is taken and every byte checked, then let the pipe settle.
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || decoded_bytes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // One well-formed token with random content.
   task automatic push_token();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         push_req(8'($urandom_range(1, LAST_CHAR_CODE)));
      end else if (pick < 60) begin
         push_req(ESCAPE_CODE);
         push_req(($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end else begin
         // Mostly short distances, so that copies find their history.
         if ($urandom_range(3) == 0)
            push_req(8'($urandom_range(COPY_BASE, 255)));
         else
            push_req(COPY_BASE + 8'($urandom_range(1)));
         push_req(8'($urandom));
      end
   endtask

   // Mostly fresh streams of tokens, with bursts of raw noise between them.
   task automatic push_random(int count);
      int          goal;
      request_type r;
      goal = pushed_count + count;
      while (pushed_count < goal) begin
         if ($urandom_range(99) < 85) begin
            new_stream = 1'b1;
            repeat ($urandom_range(3, 16)) push_token();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               r.code  = 8'($urandom);
               r.start = ($urandom_range(7) == 0);
               pending_reqs.insert(pending_reqs.size(), r);
               pushed_count++;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 14;
      rx_idle_pct = 49;

      // Every token kind with no length limit in the way.
      write_length(16'hffff);
      new_stream = 1'b1;
      push_req(8'h01);
      push_req(LAST_CHAR_CODE);
      push_req(8'h1e);
      push_req(ESCAPE_CODE);
      push_req(8'hff);
      push_req(COPY_BASE);
      push_req(8'h01);          // distance 1, two bytes
      push_req(COPY_BASE);
      push_req(8'hf3);          // distance 3, seventeen bytes
      push_req(8'hff);
      push_req(8'hff);          // farthest distance: history too short
      push_req(COPY_BASE);
      push_req(8'h50);          // distance zero halts the stream
      push_req(8'h05);          // ignored while halted
      new_stream = 1'b1;
      push_req(8'h02);
      push_req(ESCAPE_CODE);
      push_req(ESCAPE_CODE);    // escaped zero halts the stream
      push_req(8'h03);
      wait_drained();

      // A copy started just below the limit runs past it; later tokens are dropped.
      write_length(16'd3);
      new_stream = 1'b1;
      push_req(8'h10);
      push_req(8'h11);
      push_req(COPY_BASE);
      push_req(8'hf1);
      push_req(8'h12);
      push_req(ESCAPE_CODE);
      push_req(8'h41);
      wait_drained();

      // Zero limit: nothing starts.
      write_length(16'd0);
      push_random(10);
      wait_drained();

      write_length(16'($urandom_range(20, 300)));
      push_random(60);
      wait_drained();

      tx_idle_pct = 49;
      rx_idle_pct = 14;
      write_length(16'hffff);
      push_random(55);
      wait_drained();

      // No idling; hold the receiver off long enough to back up the request side.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_length(16'($urandom_range(1, 65535)));
      push_random(55);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      rsp_hold <= 1'b0;
      wait_drained();

      if (errors == 0)
         $display("byte_lz_code_decoder_top verification clean");
      else
         $display("byte_lz_code_decoder_top verification failed");
      $finish;
   end

endmodule
